/* rtl/ibpq_pkg.sv */
// Shared types and constants for the IR beacon period qualifier.
`timescale 1ns / 1ps
package ibpq_pkg;

  localparam int PERIOD_W   = 16;
  localparam int CAP_W      = 32;
  localparam int RUN_W      = 32;
  localparam int MATCH_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // operation field codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PERIOD = 3'd0,
    REG_MAX_PERIOD = 3'd1,
    REG_FINDER_EN  = 3'd2,
    REG_BEACON     = 3'd3,
    REG_TOLERANCE  = 3'd4,
    REG_THRESHOLD  = 3'd5
  } cfg_reg_e;

  // reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = 16'd480;
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = 16'd820;
  localparam logic [PERIOD_W-1:0] BEACON_RST     = 16'd0;
  localparam logic [PERIOD_W-1:0] TOLERANCE_RST  = 16'd10;
  localparam logic [MATCH_W-1:0]  THRESHOLD_RST  = 4'd15;

  typedef struct packed {
    logic [PERIOD_W-1:0] min_period;
    logic [PERIOD_W-1:0] max_period;
    logic                finder_en;
    logic [PERIOD_W-1:0] beacon;
    logic [PERIOD_W-1:0] tolerance;
    logic [MATCH_W-1:0]  threshold;
  } cfg_t;

  // flags carried from the capture stage to the qualify stage
  typedef struct packed {
    logic op_clear;   // beat clears the run count
    logic too_long;   // tick delta is 65536 us or more
  } front_beat_t;

endpackage

/* rtl/ibpq_cfg.sv */
// Configuration register file of the IR beacon period qualifier.
`timescale 1ns / 1ps
module ibpq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ibpq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ibpq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ibpq_pkg::cfg_t                   cfg
);
  import ibpq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_PERIOD: cfg_nxt.min_period = cfg_wdata[PERIOD_W-1:0];
        REG_MAX_PERIOD: cfg_nxt.max_period = cfg_wdata[PERIOD_W-1:0];
        REG_FINDER_EN:  cfg_nxt.finder_en  = cfg_wdata[0];
        REG_BEACON:     cfg_nxt.beacon     = cfg_wdata[PERIOD_W-1:0];
        REG_TOLERANCE:  cfg_nxt.tolerance  = cfg_wdata[PERIOD_W-1:0];
        REG_THRESHOLD:  cfg_nxt.threshold  = cfg_wdata[MATCH_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_period <= MIN_PERIOD_RST;
      cfg_r.max_period <= MAX_PERIOD_RST;
      cfg_r.finder_en  <= 1'b0;
      cfg_r.beacon     <= BEACON_RST;
      cfg_r.tolerance  <= TOLERANCE_RST;
      cfg_r.threshold  <= THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/ibpq_front.sv */
// Capture stage: tick delta against the previous capture, input register.
`timescale 1ns / 1ps
module ibpq_front #(
  parameter int US_TICKS = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_operation,
  input  logic [ibpq_pkg::CAP_W-1:0]             in_capture_time,
  input  logic                                   down_ready,
  output logic                                   beat_valid,
  output ibpq_pkg::front_beat_t                  beat,
  output logic [ibpq_pkg::PERIOD_W+$clog2(US_TICKS)-1:0] beat_ticks
);
  import ibpq_pkg::*;

  localparam int TICK_W = PERIOD_W + $clog2(US_TICKS);
  // first delta whose period no longer fits 16 bits
  localparam logic [CAP_W-1:0] LONG_LIMIT = CAP_W'((64'd1 << PERIOD_W) * 64'(US_TICKS));

  logic              valid_r, valid_nxt;
  logic [CAP_W-1:0]  prev_r, prev_nxt;
  front_beat_t       beat_r;
  logic [TICK_W-1:0] ticks_r;
  logic [CAP_W-1:0]  delta;
  logic              accept;
  logic              stage_ready;

  assign stage_ready = !valid_r || down_ready;
  assign in_stall    = !stage_ready;
  assign accept      = in_valid && stage_ready;
  assign delta       = in_capture_time - prev_r;

  always_comb begin
    valid_nxt = valid_r && !down_ready;
    prev_nxt  = prev_r;
    if (accept) begin
      valid_nxt = 1'b1;
      if (in_operation == OP_CAPTURE) begin
        prev_nxt = in_capture_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      prev_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      prev_r  <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r.op_clear <= (in_operation == OP_CLEAR);
      beat_r.too_long <= (delta >= LONG_LIMIT);
      ticks_r         <= delta[TICK_W-1:0];
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;
  assign beat_ticks = ticks_r;

endmodule

/* rtl/ibpq_core.sv */
// Qualify stage: period divide, window and beacon checks, result register.
`timescale 1ns / 1ps
module ibpq_core #(
  parameter int US_TICKS = 40
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ibpq_pkg::cfg_t                         cfg,
  input  logic                                   beat_valid,
  input  ibpq_pkg::front_beat_t                  beat,
  input  logic [ibpq_pkg::PERIOD_W+$clog2(US_TICKS)-1:0] beat_ticks,
  output logic                                   down_ready,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ibpq_pkg::PERIOD_W-1:0]          out_period_us,
  output logic                                   out_period_valid,
  output logic                                   out_edge_rejected,
  output logic [ibpq_pkg::RUN_W-1:0]             out_run_count,
  output logic                                   out_beacon_aligned
);
  import ibpq_pkg::*;

  // reciprocal divide, exact for any delta below 2^TICK_W
  localparam int DIV_L  = $clog2(US_TICKS);
  localparam int TICK_W = PERIOD_W + DIV_L;
  localparam int DIV_S  = TICK_W + DIV_L;
  localparam int MUL_W  = TICK_W + 1;
  localparam int PROD_W = TICK_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << DIV_S) + 64'(US_TICKS) - 64'd1) / 64'(US_TICKS));

  logic                first_r, first_nxt;
  logic [PERIOD_W-1:0] vper_r, vper_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [MATCH_W-1:0]  match_r, match_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                pvalid_nxt, reject_nxt, align_nxt;
  logic                pvalid_r, reject_r, align_r;
  logic [PERIOD_W-1:0] oper_r;
  logic [RUN_W-1:0]    orun_r;

  logic [PROD_W-1:0]   prod;
  logic [PERIOD_W-1:0] per;
  logic                in_window;
  logic [PERIOD_W-1:0] lo_bound;
  logic [PERIOD_W:0]   hi_bound;
  logic                on_beacon;
  logic [MATCH_W-1:0]  match_inc;
  logic                fire;

  assign down_ready = !ovalid_r || !out_stall;
  assign fire       = beat_valid && down_ready;

  assign prod = {{MUL_W{1'b0}}, beat_ticks} * {{TICK_W{1'b0}}, RECIP};
  assign per  = prod[DIV_S +: PERIOD_W];

  assign in_window = !beat.too_long && (per < cfg.max_period) && (per > cfg.min_period);

  // lower bound saturates at zero, upper keeps its carry
  assign lo_bound  = (cfg.beacon > cfg.tolerance) ? (cfg.beacon - cfg.tolerance) : '0;
  assign hi_bound  = {1'b0, cfg.beacon} + {1'b0, cfg.tolerance};
  assign on_beacon = (per >= lo_bound) && ({1'b0, per} <= hi_bound);
  assign match_inc = match_r + 1'b1;

  always_comb begin
    first_nxt  = first_r;
    vper_nxt   = vper_r;
    run_nxt    = run_r;
    match_nxt  = match_r;
    pvalid_nxt = 1'b0;
    reject_nxt = 1'b0;
    align_nxt  = 1'b0;
    if (fire) begin
      if (beat.op_clear) begin
        run_nxt = '0;
      end else if (first_r) begin
        first_nxt = 1'b0;
      end else if (!in_window) begin
        first_nxt  = 1'b1;
        vper_nxt   = '0;
        reject_nxt = 1'b1;
      end else begin
        pvalid_nxt = 1'b1;
        run_nxt    = run_r + 1'b1;
        vper_nxt   = per;
        if (cfg.finder_en) begin
          if (on_beacon) begin
            if (match_inc >= cfg.threshold) begin
              align_nxt = 1'b1;
              match_nxt = '0;
            end else begin
              match_nxt = match_inc;
            end
          end else begin
            match_nxt = '0;
          end
        end
      end
    end
  end

  assign ovalid_nxt = fire || (ovalid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      vper_r   <= '0;
      run_r    <= '0;
      match_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      first_r  <= first_nxt;
      vper_r   <= vper_nxt;
      run_r    <= run_nxt;
      match_r  <= match_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      oper_r   <= vper_nxt;
      pvalid_r <= pvalid_nxt;
      reject_r <= reject_nxt;
      orun_r   <= run_nxt;
      align_r  <= align_nxt;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_period_us      = oper_r;
  assign out_period_valid   = pvalid_r;
  assign out_edge_rejected  = reject_r;
  assign out_run_count      = orun_r;
  assign out_beacon_aligned = align_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_period_valid && out_edge_rejected))
    else $error("period both valid and rejected");

  a_aligned_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beacon_aligned) |-> out_period_valid)
    else $error("aligned pulse without an in-window period");

  a_valid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_period_valid) |->
      (out_period_us > cfg.min_period && out_period_us < cfg.max_period))
    else $error("validated period outside the window");

  a_reject_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_edge_rejected) |-> (out_period_us == '0 && !out_beacon_aligned))
    else $error("rejected edge left a period");

  a_reject_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && reject_nxt) |=> first_r)
    else $error("rejection did not re-arm first edge");

endmodule

/* rtl/ir_beacon_period_qualifier.sv */
// Top level of the IR beacon period qualifier.
`timescale 1ns / 1ps
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------------
//  in_     | in        | in_valid/in_stall | operation, capture_time
//  out_    | out       | out_valid/out_stall| period_us, period_valid, edge_rejected,
//          |           |                   | run_count, beacon_aligned
//  cfg_    | in        | cfg_wr_en         | cfg_index, cfg_wdata (write only)
//
//  One beat per cycle in and out while out_stall is low. In order,
//  the capture stage registers the tick delta, then the qualify stage runs the
//  reciprocal multiply and the window/beacon checks into the result register.
//  Synchronous reset: first-edge armed, counts and validated period zero,
//  registers at their defaults. No clearing pass.
//  A stalled result holds; the capture stage still takes a beat while its
//  own register is free, so stall reaches in_stall only when both stages hold.
//
module ir_beacon_period_qualifier #(
  parameter int US_TICKS = 40
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // capture input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_operation,
  input  logic [ibpq_pkg::CAP_W-1:0]       in_capture_time,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ibpq_pkg::PERIOD_W-1:0]    out_period_us,
  output logic                             out_period_valid,
  output logic                             out_edge_rejected,
  output logic [ibpq_pkg::RUN_W-1:0]       out_run_count,
  output logic                             out_beacon_aligned,
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [ibpq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ibpq_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ibpq_pkg::*;

  localparam int TICK_W = PERIOD_W + $clog2(US_TICKS);

  cfg_t              cfg;
  logic              beat_valid;
  front_beat_t       beat;
  logic [TICK_W-1:0] beat_ticks;
  logic              down_ready;

  ibpq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // previous capture lives here; delta computed as the beat is taken
  ibpq_front #(
    .US_TICKS (US_TICKS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_capture_time (in_capture_time),
    .down_ready      (down_ready),
    .beat_valid      (beat_valid),
    .beat            (beat),
    .beat_ticks      (beat_ticks)
  );

  // first-edge flag, validated period, run and match counts live here
  ibpq_core #(
    .US_TICKS (US_TICKS)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .beat_valid         (beat_valid),
    .beat               (beat),
    .beat_ticks         (beat_ticks),
    .down_ready         (down_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_period_us      (out_period_us),
    .out_period_valid   (out_period_valid),
    .out_edge_rejected  (out_edge_rejected),
    .out_run_count      (out_run_count),
    .out_beacon_aligned (out_beacon_aligned)
  );

endmodule
